// ===== hw/rtl/ffua_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the first-fit unit allocator
package ffua_pkg;

  localparam int unsigned OpW     = 1;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned StartW  = 10;
  localparam int unsigned CountW  = 11;
  localparam int unsigned UnitCfgW = 11;

  localparam logic [OpW-1:0] OP_ALLOC = 1'b0;
  localparam logic [OpW-1:0] OP_FREE  = 1'b1;

  localparam logic [UnitCfgW-1:0] MemUnitsRst = 11'd1024;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [SizeW-1:0]  block_size;
    logic [OwnerW-1:0] owner_id;
  } req_t;

  typedef struct packed {
    logic [StartW-1:0] start_index;
    logic              alloc_ok;
    logic [CountW-1:0] freed_count;
  } rsp_t;

endpackage

// ===== hw/rtl/first_fit_unit_allocator.sv =====
`timescale 1ns / 1ps
// first-fit unit allocator top level
//
// request channel: in_valid_i / in_stall_o carry one item, either an allocate
// (block_size units for owner_id) or a free of every unit owned by owner_id.
// result channel: out_valid_o / out_stall_i return one item per request, in
// order: start_index and alloc_ok for allocate, freed_count for free.
// cfg_wr_en_i writes memory_units, the number of units that take part in
// requests; write it only while no request is in flight.
// after reset the unit store is swept once to mark every unit free, and
// in_stall_o is high during the sweep.
// the state lives in one memory with one read and one write port; a request
// reads it one unit per cycle: an allocate scans up to limit units and then
// marks the block_size units of the run that it found, and a free scans limit
// units, where limit is the smaller of memory_units and MaxUnits.
// one request is worked on at a time; the result sits in an output register,
// so the next request is taken while a stalled result waits. while that
// result is still stalled, a finished request holds until it can move on.
module first_fit_unit_allocator #(
  parameter int unsigned MaxUnits = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ffua_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ffua_pkg::rsp_t                out_data_o,
  input  logic                          cfg_wr_en_i,
  input  logic [ffua_pkg::UnitCfgW-1:0] cfg_wr_data_i
);
  import ffua_pkg::*;

  logic [UnitCfgW-1:0] mem_units_q;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_data_q;
  logic                eng_ready;
  logic                eng_done;
  rsp_t                eng_rsp;
  logic                eng_take;
  logic                in_accept;

  assign in_accept = in_valid_i && eng_ready;
  assign eng_take  = eng_done && (!out_valid_q || !out_stall_i);

  ffua_engine #(
    .MaxUnits (MaxUnits)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .req_i       (in_data_i),
    .mem_units_i (mem_units_q),
    .ready_o     (eng_ready),
    .done_o      (eng_done),
    .rsp_o       (eng_rsp),
    .take_i      (eng_take)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (eng_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_units_q <= MemUnitsRst;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        mem_units_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_take) begin
      out_data_q <= eng_rsp;
    end
  end

  assign in_stall_o  = !eng_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/ffua_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read
module ffua_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ffua_engine.sv =====
`timescale 1ns / 1ps
// sequencer that clears, scans, fills and frees the unit store
module ffua_engine #(
  parameter int unsigned MaxUnits = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  ffua_pkg::req_t            req_i,
  input  logic [ffua_pkg::UnitCfgW-1:0] mem_units_i,
  output logic                      ready_o,
  output logic                      done_o,
  output ffua_pkg::rsp_t            rsp_o,
  input  logic                      take_i
);
  import ffua_pkg::*;

  localparam int unsigned AW    = $clog2(MaxUnits);
  localparam int unsigned CntW  = $clog2(MaxUnits + 1);
  localparam int unsigned WideW = (CntW > UnitCfgW) ? CntW : UnitCfgW;
  localparam int unsigned UnitW = OwnerW + 1;
  localparam logic [AW-1:0]    LastAddr = AW'(MaxUnits - 1);
  localparam logic [WideW-1:0] MaxWide  = WideW'(MaxUnits);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FILL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_addr_q, clr_addr_d;
  logic              vld_q, vld_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic [OwnerW-1:0] tag_q, tag_d;
  logic [CntW-1:0]   limit_q, limit_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic [AW-1:0]     chk_idx_q, chk_idx_d;
  logic [SizeW-1:0]  run_q, run_d;
  logic [AW-1:0]     fill_addr_q, fill_addr_d;
  logic [SizeW-1:0]  fill_cnt_q, fill_cnt_d;
  logic              ok_q, ok_d;
  logic [StartW-1:0] start_q, start_d;
  logic [CntW-1:0]   freed_q, freed_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [UnitW-1:0]  mem_wdata;
  logic [UnitW-1:0]  mem_rdata;
  logic              rd_issue;
  logic              rd_used;
  logic [OwnerW-1:0] rd_owner;
  logic [WideW-1:0]  mem_units_w;
  logic [WideW-1:0]  limit_w;
  logic [WideW-1:0]  start_w;
  logic [WideW-1:0]  freed_w;
  logic [SizeW-1:0]  run_inc;
  logic              last_chk;
  logic              fit_hit;
  logic              free_hit;

  ffua_ram #(
    .Width (UnitW),
    .Depth (MaxUnits)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign rd_used     = mem_rdata[OwnerW];
  assign rd_owner    = mem_rdata[OwnerW-1:0];
  assign mem_units_w = WideW'(mem_units_i);
  assign limit_w     = (mem_units_w > MaxWide) ? MaxWide : mem_units_w;
  assign rd_issue    = (state_q == ST_SCAN) && (rd_idx_q < limit_q);
  assign last_chk    = (CntW'(chk_idx_q) + CntW'(1)) == limit_q;
  assign run_inc     = run_q + SizeW'(1);
  assign fit_hit     = vld_q && !rd_used && (run_inc == size_q);
  assign free_hit    = vld_q && rd_used && (rd_owner == tag_q);
  assign start_w     = WideW'(chk_idx_q) + WideW'(1) - WideW'(size_q);
  assign freed_w     = WideW'(freed_q);

  assign ready_o = (state_q == ST_IDLE);
  assign done_o  = (state_q == ST_DONE);
  assign rsp_o.start_index = start_q;
  assign rsp_o.alloc_ok    = ok_q;
  assign rsp_o.freed_count = freed_w[CountW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
      end
      ST_SCAN: begin
        if (op_q == OP_FREE && free_hit) begin
          mem_we    = 1'b1;
          mem_waddr = chk_idx_q;
          mem_wdata = {1'b0, rd_owner};
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr_q;
        mem_wdata = {1'b1, tag_q};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    vld_d       = vld_q;
    op_d        = op_q;
    size_d      = size_q;
    tag_d       = tag_q;
    limit_d     = limit_q;
    rd_idx_d    = rd_idx_q;
    chk_idx_d   = chk_idx_q;
    run_d       = run_q;
    fill_addr_d = fill_addr_q;
    fill_cnt_d  = fill_cnt_q;
    ok_d        = ok_q;
    start_d     = start_q;
    freed_d     = freed_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d     = req_i.operation;
          size_d   = req_i.block_size;
          tag_d    = req_i.owner_id;
          limit_d  = CntW'(limit_w);
          rd_idx_d = '0;
          vld_d    = 1'b0;
          run_d    = '0;
          ok_d     = 1'b0;
          start_d  = '0;
          freed_d  = '0;
          if (limit_w == '0 || (req_i.operation == OP_ALLOC && req_i.block_size == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        vld_d     = rd_issue;
        chk_idx_d = rd_idx_q[AW-1:0];
        if (rd_issue) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (vld_q) begin
          if (op_q == OP_ALLOC) begin
            run_d = rd_used ? '0 : run_inc;
            if (fit_hit) begin
              ok_d        = 1'b1;
              start_d     = start_w[StartW-1:0];
              fill_addr_d = AW'(start_w);
              fill_cnt_d  = size_q;
              vld_d       = 1'b0;
              state_d     = ST_FILL;
            end else if (last_chk) begin
              vld_d   = 1'b0;
              state_d = ST_DONE;
            end
          end else begin
            if (free_hit) begin
              freed_d = freed_q + CntW'(1);
            end
            if (last_chk) begin
              vld_d   = 1'b0;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_FILL: begin
        fill_addr_d = fill_addr_q + AW'(1);
        fill_cnt_d  = fill_cnt_q - SizeW'(1);
        if (fill_cnt_q == SizeW'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      vld_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      vld_q      <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    size_q      <= size_d;
    tag_q       <= tag_d;
    limit_q     <= limit_d;
    rd_idx_q    <= rd_idx_d;
    chk_idx_q   <= chk_idx_d;
    run_q       <= run_d;
    fill_addr_q <= fill_addr_d;
    fill_cnt_q  <= fill_cnt_d;
    ok_q        <= ok_d;
    start_q     <= start_d;
    freed_q     <= freed_d;
  end

endmodule

// ===== bench/first_fit_unit_allocator_chk.sv =====
`timescale 1ns / 1ps
// watches the allocator channels, predicts every result and compares it
module first_fit_unit_allocator_chk #(
  parameter int unsigned MaxUnits = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  ffua_pkg::req_t                in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  ffua_pkg::rsp_t                out_data_i,
  input  logic                          cfg_wr_en_i,
  input  logic [ffua_pkg::UnitCfgW-1:0] cfg_wr_data_i,
  output int                            mismatches_o,
  output int                            pending_o
);
  import ffua_pkg::*;

  logic                 unit_busy [MaxUnits];
  logic [OwnerW-1:0]    unit_tag  [MaxUnits];
  logic [UnitCfgW-1:0]  units_cfg;
  rsp_t                 rsp_due [$];
  int                   mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic rsp_t grant_or_release(input req_t r);
    rsp_t        res;
    int unsigned lim;
    int unsigned run;
    int unsigned first;
    int unsigned freed;
    bit          found;
    lim   = (units_cfg > MaxUnits) ? MaxUnits : units_cfg;
    res   = '0;
    run   = 0;
    first = 0;
    freed = 0;
    found = 1'b0;
    if (r.operation == OP_ALLOC) begin
      if (r.block_size != '0) begin
        for (int unsigned i = 0; i < lim && !found; i++) begin
          if (unit_busy[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == r.block_size) begin
              first = i + 1 - r.block_size;
              found = 1'b1;
            end
          end
        end
      end
      if (found) begin
        for (int unsigned i = first; i < first + r.block_size; i++) begin
          unit_busy[i] = 1'b1;
          unit_tag[i]  = r.owner_id;
        end
      end
    end else begin
      for (int unsigned i = 0; i < lim; i++) begin
        if (unit_busy[i] && unit_tag[i] == r.owner_id) begin
          unit_busy[i] = 1'b0;
          freed++;
        end
      end
    end
    res.start_index = found ? first[StartW-1:0] : '0;
    res.alloc_ok    = found;
    res.freed_count = freed[CountW-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MaxUnits; i++) begin
        unit_busy[i] = 1'b0;
        unit_tag[i]  = '0;
      end
      units_cfg = MemUnitsRst;
      rsp_due.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rsp_due.size() == 0) begin
          report_mismatch("result item with no request waiting");
        end else begin
          want = rsp_due.pop_front();
          if (out_data_i.start_index !== want.start_index)
            report_mismatch($sformatf("start_index got %0d want %0d",
                                      out_data_i.start_index, want.start_index));
          if (out_data_i.alloc_ok !== want.alloc_ok)
            report_mismatch($sformatf("alloc_ok got %0b want %0b",
                                      out_data_i.alloc_ok, want.alloc_ok));
          if (out_data_i.freed_count !== want.freed_count)
            report_mismatch($sformatf("freed_count got %0d want %0d",
                                      out_data_i.freed_count, want.freed_count));
        end
      end
      if (in_valid_i && !in_stall_i) rsp_due.push_back(grant_or_release(in_data_i));
      if (cfg_wr_en_i) units_cfg = cfg_wr_data_i;
      pending_o <= rsp_due.size();
    end
    mismatches_o <= mismatches;
  end

endmodule

// ===== bench/first_fit_unit_allocator_tb.sv =====
`timescale 1ns / 1ps
// top of the allocator bench: stimulus, receiver stalls and the verdict
module first_fit_unit_allocator_tb;
  import ffua_pkg::*;

  localparam int unsigned MaxUnits = 1024;
  localparam int unsigned PoolN    = 6;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                req_valid   = 1'b0;
  logic                req_stall;
  req_t                req_item    = '0;
  logic                rsp_valid;
  logic                rsp_stall   = 1'b0;
  rsp_t                rsp_item;
  logic                units_we    = 1'b0;
  logic [UnitCfgW-1:0] units_wdata = '0;

  int                  mismatches;
  int                  pending;
  int unsigned         cur_units   = MemUnitsRst;
  int unsigned         burst_left  = 0;
  bit                  steady      = 1'b0;
  bit                  hold_req    = 1'b0;
  logic [OwnerW-1:0]   owner_pool [PoolN];

  first_fit_unit_allocator #(.MaxUnits(MaxUnits)) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_stall_o   (req_stall),
    .in_data_i    (req_item),
    .out_valid_o  (rsp_valid),
    .out_stall_i  (rsp_stall),
    .out_data_o   (rsp_item),
    .cfg_wr_en_i  (units_we),
    .cfg_wr_data_i(units_wdata)
  );

  first_fit_unit_allocator_chk #(.MaxUnits(MaxUnits)) u_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_stall_i   (req_stall),
    .in_data_i    (req_item),
    .out_valid_i  (rsp_valid),
    .out_stall_i  (rsp_stall),
    .out_data_i   (rsp_item),
    .cfg_wr_en_i  (units_we),
    .cfg_wr_data_i(units_wdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic req_t make_req(input logic [OpW-1:0] op, input int unsigned size,
                                    input logic [OwnerW-1:0] owner);
    req_t r;
    r.operation  = op;
    r.block_size = SizeW'(size);
    r.owner_id   = owner;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned lim;
    int unsigned pick;
    lim          = (cur_units > MaxUnits) ? MaxUnits : cur_units;
    pick         = $urandom_range(0, 99);
    r.block_size = SizeW'($urandom());
    r.owner_id   = owner_pool[$urandom_range(0, PoolN - 1)];
    if ($urandom_range(0, 9) == 0) r.owner_id = OwnerW'($urandom());
    if (pick < 62) begin
      r.operation = OP_ALLOC;
      pick = $urandom_range(0, 19);
      if (pick == 1) r.block_size = '0;
      else if (pick < 4) r.block_size = SizeW'(lim + $urandom_range(0, 2) - 1);
      else if (pick > 0) r.block_size = SizeW'($urandom_range(1, lim / 4 + 1));
    end else begin
      r.operation = OP_FREE;
    end
    return r;
  endfunction

  task automatic offer_req(input req_t r);
    int unsigned gap;
    req_valid <= 1'b1;
    req_item  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(20, 300) : $urandom_range(1, 8);
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain_rsps();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_unit_count(input int unsigned v);
    drain_rsps();
    repeat (4) @(posedge clk);
    units_we    <= 1'b1;
    units_wdata <= UnitCfgW'(v);
    @(posedge clk);
    units_we    <= 1'b0;
    cur_units = v;
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned tick;
    mode = 0;
    left = 0;
    tick = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(30, 400);
      end
      left--;
      tick++;
      case (mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= ((tick % 7) < 3);
      endcase
      @(posedge clk);
    end
  end

  initial begin
    int unsigned plan_units [10];
    int unsigned plan_items [10];
    plan_units = '{1, 2047, 16, 64, 0, 1024, 7, 40, 0, 128};
    plan_items = '{60, 20, 70, 70, 20, 20, 70, 70, 70, 90};
    for (int k = 0; k < PoolN; k++) owner_pool[k] = OwnerW'($urandom());
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero size, full store, oversized, holes and exact fits
    offer_req(make_req(OP_ALLOC, 0, 16'h0001));
    offer_req(make_req(OP_ALLOC, 1024, 16'hFFFF));
    offer_req(make_req(OP_ALLOC, 1, 16'h0002));
    offer_req(make_req(OP_FREE, 2047, 16'hFFFF));
    offer_req(make_req(OP_ALLOC, 2047, 16'h0003));
    offer_req(make_req(OP_ALLOC, 1025, 16'h0003));
    offer_req(make_req(OP_ALLOC, 1, 16'h0000));
    offer_req(make_req(OP_ALLOC, 3, 16'hAAAA));
    offer_req(make_req(OP_ALLOC, 5, 16'h5555));
    offer_req(make_req(OP_FREE, 0, 16'hAAAA));
    offer_req(make_req(OP_ALLOC, 4, 16'h00F0));
    offer_req(make_req(OP_ALLOC, 3, 16'h0F00));
    offer_req(make_req(OP_ALLOC, 1, 16'h0F00));
    // zero unit count
    set_unit_count(0);
    offer_req(make_req(OP_ALLOC, 1, 16'h0007));
    offer_req(make_req(OP_FREE, 0, 16'h0F00));
    // shrink while units are held
    set_unit_count(4);
    offer_req(make_req(OP_FREE, 0, 16'h0F00));
    offer_req(make_req(OP_ALLOC, 2, 16'h5555));
    // count above the store size
    set_unit_count(2047);
    offer_req(make_req(OP_FREE, 0, 16'h0F00));
    offer_req(make_req(OP_FREE, 0, 16'h5555));
    offer_req(make_req(OP_ALLOC, 1020, 16'h1234));
    offer_req(make_req(OP_ALLOC, 1011, 16'h1234));
    set_unit_count(1);
    offer_req(make_req(OP_FREE, 0, 16'h0000));
    offer_req(make_req(OP_ALLOC, 1, 16'hFFFF));
    offer_req(make_req(OP_ALLOC, 2, 16'hFFFF));

    for (int p = 0; p < 10; p++) begin
      set_unit_count(p == 8 ? $urandom_range(2, 100) : plan_units[p]);
      owner_pool[$urandom_range(0, PoolN - 1)] = OwnerW'($urandom());
      owner_pool[$urandom_range(0, PoolN - 1)] = OwnerW'($urandom());
      steady = (p == 3) || (p == 6);
      if (p == 3) hold_req = 1'b1;
      for (int n = 0; n < plan_items[p]; n++) begin
        if (p == 7 && n == 35) drain_rsps();
        offer_req(random_req());
      end
    end
    steady = 1'b0;

    drain_rsps();
    repeat (2200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
